[design/tdwq_pkg.sv]
// Package for the timer delta wait queue.
// Holds payload structs, the stored entry type and the operation and result codes.
// No dependencies.
`default_nettype none

package tdwq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS         = 8;
    localparam int DELAY_BITS      = 16;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [1:0] KIND_ACCEPT  = 2'd0;
    localparam logic [1:0] KIND_REJECT  = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    typedef struct packed {
        logic                  func;
        logic [ID_BITS-1:0]    thread_id;
        logic [DELAY_BITS-1:0] wait_ticks;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic [ID_BITS-1:0] released_id;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [ID_BITS-1:0]    thread;
        logic [DELAY_BITS-1:0] delta;
    } t_entry;

endpackage

`default_nettype wire

[design/tdwq_ram.sv]
// Entry store of the wait queue: one write port, one registered read port.
// Depends on tdwq_pkg for the entry type.
`default_nettype none

module tdwq_ram
    import tdwq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_entry             o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_entry        i_wr_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[design/timer_delta_wait_queue.sv]
// Timer delta wait queue: sequencer over a circular entry store.
// Add: walk to the insert point, shift later entries up; if empty or full, straight to the result.
// Tick: releases due entries one per cycle from the one read port while the output is not stalled.
// One item at a time; the next is taken once the last transfer is in the output register.
// Reset clears count, head, sequencer and output valid; the store needs no clearing.
// Depends on tdwq_pkg and tdwq_ram.
`default_nettype none

module timer_delta_wait_queue
    import tdwq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_item i_data,
    output logic          o_stall,
    output logic          o_valid,
    output t_out_item     o_data,
    input  wire logic     i_stall
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_SHIFT,
        S_ADD_RES,
        S_TICK_HEAD,
        S_TICK_NEXT
    } t_state;

    t_state                r_state, n_state;
    logic [AW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_pos, n_pos;
    logic [CW-1:0]         r_src, n_src;
    logic [DELAY_BITS-1:0] r_rest, n_rest;
    logic [ID_BITS-1:0]    r_id, n_id;
    logic                  r_full, n_full;
    logic [ID_BITS-1:0]    r_pend, n_pend;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    t_entry                rd_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    t_entry                wr_data;
    logic                  can_emit;
    logic                  in_xfer;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] idx);
        logic [AW+1:0] s;
        s = (AW+2)'(head) + (AW+2)'(idx);
        if (s >= (AW+2)'(QUEUE_DEPTH)) begin
            s = s - (AW+2)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    tdwq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign in_xfer  = i_valid && !o_stall;
    assign can_emit = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_comb begin
        logic [DELAY_BITS-1:0] dec;
        logic [CW-1:0]         pos_inc;
        logic [AW-1:0]         head_inc;
        logic [CW-1:0]         cnt_dec;

        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_pos       = r_pos;
        n_src       = r_src;
        n_rest      = r_rest;
        n_id        = r_id;
        n_full      = r_full;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        rd_en       = 1'b0;
        rd_addr     = r_head;
        wr_en       = 1'b0;
        wr_addr     = r_head;
        wr_data     = rd_data;

        dec      = rd_data.delta - DELAY_BITS'(1);
        pos_inc  = r_pos + CW'(1);
        head_inc = f_phys(r_head, CW'(1));
        cnt_dec  = r_count - CW'(1);

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_data.func == FUNC_ADD) begin
                        n_id   = i_data.thread_id;
                        n_rest = (i_data.wait_ticks == '0) ? DELAY_BITS'(1) : i_data.wait_ticks;
                        n_pos  = '0;
                        n_full = (r_count == CW'(QUEUE_DEPTH));
                        if (r_count == CW'(QUEUE_DEPTH) || r_count == '0) begin
                            n_state = S_ADD_RES;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_head;
                            n_state = S_WALK;
                        end
                    end else if (r_count != '0) begin
                        rd_en   = 1'b1;
                        rd_addr = r_head;
                        n_state = S_TICK_HEAD;
                    end
                end
            end
            S_WALK: begin
                if (rd_data.delta <= r_rest) begin
                    n_rest = r_rest - rd_data.delta;
                    n_pos  = pos_inc;
                    if (pos_inc == r_count) begin
                        n_state = S_ADD_RES;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = f_phys(r_head, pos_inc);
                    end
                end else begin
                    n_src   = cnt_dec;
                    rd_en   = 1'b1;
                    rd_addr = f_phys(r_head, cnt_dec);
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // entry moves up one place; the follower of the new entry loses the rest
                wr_en   = 1'b1;
                wr_addr = f_phys(r_head, r_src + CW'(1));
                wr_data = rd_data;
                if (r_src == r_pos) begin
                    wr_data.delta = rd_data.delta - r_rest;
                    n_state       = S_ADD_RES;
                end else begin
                    n_src   = r_src - CW'(1);
                    rd_en   = 1'b1;
                    rd_addr = f_phys(r_head, r_src - CW'(1));
                end
            end
            S_ADD_RES: begin
                if (can_emit) begin
                    n_out_valid       = 1'b1;
                    n_out.kind        = r_full ? KIND_REJECT : KIND_ACCEPT;
                    n_out.released_id = r_id;
                    n_out.last        = 1'b1;
                    if (!r_full) begin
                        wr_en          = 1'b1;
                        wr_addr        = f_phys(r_head, r_pos);
                        wr_data.thread = r_id;
                        wr_data.delta  = r_rest;
                        n_count        = r_count + CW'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            S_TICK_HEAD: begin
                if (dec != '0) begin
                    wr_en         = 1'b1;
                    wr_addr       = r_head;
                    wr_data.delta = dec;
                    n_state       = S_IDLE;
                end else begin
                    n_pend  = rd_data.thread;
                    n_head  = head_inc;
                    n_count = cnt_dec;
                    if (cnt_dec != '0) begin
                        rd_en   = 1'b1;
                        rd_addr = head_inc;
                    end
                    n_state = S_TICK_NEXT;
                end
            end
            S_TICK_NEXT: begin
                if (can_emit) begin
                    n_out_valid       = 1'b1;
                    n_out.kind        = KIND_RELEASE;
                    n_out.released_id = r_pend;
                    if (r_count == '0 || rd_data.delta != '0) begin
                        n_out.last = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_out.last = 1'b0;
                        n_pend     = rd_data.thread;
                        n_head     = head_inc;
                        n_count    = cnt_dec;
                        if (cnt_dec != '0) begin
                            rd_en   = 1'b1;
                            rd_addr = head_inc;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_pos  <= n_pos;
        r_src  <= n_src;
        r_rest <= n_rest;
        r_id   <= n_id;
        r_full <= n_full;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !wr_en)
        else $error("store written while idle");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD_RES && can_emit && !r_full) |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the queue");

    a_release_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK_NEXT && can_emit && r_count == '0) |=>
        (o_valid && o_data.last && r_state == S_IDLE))
        else $error("final release not marked last");

endmodule

`default_nettype wire

[verif/tb_timer_delta_wait_queue.sv]
`timescale 1ns / 100ps
// Self-checking testbench for timer_delta_wait_queue: directed and random add/tick traffic
// with random idling on both channels, results checked against an in-bench wait list.
// Depends on tdwq_pkg and the timer_delta_wait_queue RTL.

module tb_timer_delta_wait_queue
    import tdwq_pkg::*;
();

    localparam int QUEUE_DEPTH  = QUEUE_DEPTH_DEF;
    localparam int LIMIT_CYCLES = 600000;
    localparam int SETTLE       = 2 * QUEUE_DEPTH + 40;
    localparam int RANDOM_ITEMS = 450;

    typedef struct {
        t_in_item    item;
        int unsigned gap;
        bit          drain;
    } t_stim;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    t_in_item  i_data;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_data;
    logic      i_stall;

    t_stim     stim_q[$];
    t_out_item awaited_results[$];

    // wait list mirror
    logic [ID_BITS-1:0]    wl_thread[QUEUE_DEPTH];
    logic [DELAY_BITS-1:0] wl_delta[QUEUE_DEPTH];
    int                    wl_count;

    int          cycle_cnt;
    int          err_count;
    int          n_checked;
    int          n_adds;
    int          n_ticks;
    int          n_released;
    int          n_rejects;
    int unsigned idle_cnt;
    int unsigned stall_left;

    timer_delta_wait_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_data (i_data),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .o_data (o_data),
        .i_stall(i_stall)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic advance_wait_list(input t_in_item it);
        logic [DELAY_BITS-1:0] rest;
        int                    pos;
        bit                    held;
        t_out_item             res;
        rest = it.wait_ticks;
        pos  = 0;
        held = 1'b0;
        res  = '0;
        if (it.func == FUNC_ADD) begin
            n_adds++;
            res.released_id = it.thread_id;
            res.last        = 1'b1;
            if (wl_count >= QUEUE_DEPTH) begin
                res.kind = KIND_REJECT;
                n_rejects++;
            end else begin
                res.kind = KIND_ACCEPT;
                if (rest == '0) rest = DELAY_BITS'(1);
                while (pos < wl_count && wl_delta[pos] <= rest) begin
                    rest -= wl_delta[pos];
                    pos++;
                end
                if (pos < wl_count) wl_delta[pos] = wl_delta[pos] - rest;
                for (int j = wl_count; j > pos; j--) begin
                    wl_thread[j] = wl_thread[j-1];
                    wl_delta[j]  = wl_delta[j-1];
                end
                wl_thread[pos] = it.thread_id;
                wl_delta[pos]  = rest;
                wl_count++;
            end
            awaited_results.push_back(res);
        end else begin
            n_ticks++;
            if (wl_count == 0) return;
            wl_delta[0] = wl_delta[0] - 1'b1;
            while (wl_count > 0 && wl_delta[0] == '0) begin
                if (held) awaited_results.push_back(res);
                res.kind        = KIND_RELEASE;
                res.released_id = wl_thread[0];
                res.last        = 1'b0;
                held            = 1'b1;
                n_released++;
                for (int j = 1; j < wl_count; j++) begin
                    wl_thread[j-1] = wl_thread[j];
                    wl_delta[j-1]  = wl_delta[j];
                end
                wl_count--;
            end
            if (held) begin
                res.last = 1'b1;
                awaited_results.push_back(res);
            end
        end
    endtask

    task automatic queue_item(input logic func, input logic [ID_BITS-1:0] id,
                              input logic [DELAY_BITS-1:0] ticks, input bit calm,
                              input bit drain);
        t_stim s;
        s.item.func       = func;
        s.item.thread_id  = id;
        s.item.wait_ticks = ticks;
        s.gap             = calm ? 0 : $urandom_range(0, 10);
        s.drain           = drain;
        stim_q.push_back(s);
    endtask

    function automatic logic [DELAY_BITS-1:0] random_wait();
        int unsigned r;
        r = $urandom_range(0, 63);
        if (r == 0) return DELAY_BITS'($urandom_range(0, 65535));
        if (r < 8) return DELAY_BITS'($urandom_range(0, 60));
        return DELAY_BITS'($urandom_range(0, 8));
    endfunction

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d results still awaited", $realtime,
                     awaited_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // driver
    always @(posedge i_clk) begin : driver
        int unsigned idle_next;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            i_data   <= '0;
            idle_cnt <= 0;
        end else begin
            idle_next = idle_cnt;
            if (i_valid && !o_stall) begin
                advance_wait_list(i_data);
                idle_next = 0;
            end
            if (!i_valid || !o_stall) begin
                if (stim_q.size() != 0 && idle_next >= stim_q[0].gap &&
                    (!stim_q[0].drain || awaited_results.size() == 0)) begin
                    i_valid  <= 1'b1;
                    i_data   <= stim_q[0].item;
                    idle_cnt <= 0;
                    void'(stim_q.pop_front());
                end else begin
                    i_valid  <= 1'b0;
                    idle_cnt <= idle_next + 1;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        int unsigned stall_draw;
        t_out_item   want;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else begin
            stall_draw = stall_left;
            if (o_valid && !i_stall) begin
                n_checked++;
                if (awaited_results.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected transfer kind %0d id %0h last %0d", $realtime,
                             o_data.kind, o_data.released_id, o_data.last);
                end else begin
                    want = awaited_results.pop_front();
                    if (o_data.kind !== want.kind || o_data.released_id !== want.released_id ||
                        o_data.last !== want.last) begin
                        err_count++;
                        $display("%0t: mismatch, expected %0d/%0h/%0d, got %0d/%0h/%0d",
                                 $realtime, want.kind, want.released_id, want.last,
                                 o_data.kind, o_data.released_id, o_data.last);
                    end
                end
                stall_draw = ((cycle_cnt % 3000) < 600) ? 0 : $urandom_range(0, 10);
            end
            if (stall_draw > 0) begin
                i_stall    <= 1'b1;
                stall_left <= stall_draw - 1;
            end else begin
                i_stall    <= 1'b0;
                stall_left <= 0;
            end
        end
    end

    initial begin : stimulus
        int unsigned add_pct;
        bit          calm;
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_data     = '0;
        i_stall    = 1'b0;
        cycle_cnt  = 0;
        err_count  = 0;
        n_checked  = 0;
        n_adds     = 0;
        n_ticks    = 0;
        n_released = 0;
        n_rejects  = 0;
        wl_count   = 0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            wl_thread[k] = '0;
            wl_delta[k]  = '0;
        end

        // directed: empty tick, zero delay, extremes, equal wake-up, idle tick, full queue
        queue_item(FUNC_TICK, 8'h00, 16'h0000, 1'b0, 1'b0);
        queue_item(FUNC_ADD, 8'h00, 16'h0000, 1'b0, 1'b0);
        queue_item(FUNC_ADD, 8'hFF, 16'hFFFF, 1'b0, 1'b0);
        queue_item(FUNC_ADD, 8'hAA, 16'h0001, 1'b0, 1'b0);
        queue_item(FUNC_ADD, 8'h55, 16'h0001, 1'b0, 1'b0);
        queue_item(FUNC_TICK, 8'hFF, 16'hFFFF, 1'b0, 1'b0);
        queue_item(FUNC_ADD, 8'h01, 16'h0003, 1'b0, 1'b0);
        queue_item(FUNC_TICK, 8'h00, 16'h0000, 1'b0, 1'b0);
        for (int k = 0; k < QUEUE_DEPTH - 2; k++)
            queue_item(FUNC_ADD, ID_BITS'(8'h10 + k), DELAY_BITS'(k % 5), 1'b0, 1'b0);
        queue_item(FUNC_ADD, 8'h7E, 16'h0002, 1'b0, 1'b0);
        queue_item(FUNC_TICK, 8'h00, 16'h0000, 1'b0, 1'b0);
        queue_item(FUNC_TICK, 8'h00, 16'h0000, 1'b0, 1'b1);

        // random phases of 50 items, each opening after a full drain
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: add_pct = 30;
                    1: add_pct = 50;
                    default: add_pct = 75;
                endcase
                calm = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(1, 100) <= add_pct)
                queue_item(FUNC_ADD, ID_BITS'($urandom_range(0, 255)), random_wait(), calm,
                           k % 50 == 0);
            else
                queue_item(FUNC_TICK, ID_BITS'($urandom_range(0, 255)),
                           DELAY_BITS'($urandom_range(0, 65535)), calm, k % 50 == 0);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || i_valid || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Covered %0d adds (%0d rejected on a full queue), %0d ticks releasing %0d;",
                 n_adds, n_rejects, n_ticks, n_released);
        $display("%0d result transfers checked, %0d mismatches.", n_checked, err_count);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
design/tdwq_pkg.sv
design/tdwq_ram.sv
design/timer_delta_wait_queue.sv
verif/tb_timer_delta_wait_queue.sv
